>>> hw/rtl/adcl_pkg.sv
`default_nettype none
package adcl_pkg;

    localparam int DELAY_AW    = 20;
    localparam int DELAY_DEPTH = 1 << DELAY_AW;

    localparam int SAMPLE_W   = 24;
    localparam int TAP_W      = 20;
    localparam int STEP_W     = 17;
    localparam int FRAC_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int COEF_W     = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int TDATA_W    = 24;

    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 60;
    localparam int MIX_W   = 42;
    localparam int MIX_LO_W = 21;

    localparam logic [STEP_W-1:0] WEIGHT_ONE = STEP_W'(65536);
    localparam logic [FRAC_W-1:0] WET_ONE    = FRAC_W'(32768);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY, CFG_XFADE, CFG_INVERT, CFG_WET, CFG_GAIN, CFG_B0, CFG_A1, CFG_A2
    } cfg_idx_t;

    typedef struct packed {
        logic [TAP_W-1:0]         delay_samples;
        logic [STEP_W-1:0]        xfade_step;
        logic                     invert_wet;
        logic [FRAC_W-1:0]        wet_fraction;
        logic [GAIN_W-1:0]        gain_linear;
        logic signed [COEF_W-1:0] coef_b0;
        logic signed [COEF_W-1:0] coef_a1;
        logic signed [COEF_W-1:0] coef_a2;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD_OLD, ST_RD_NEW, ST_XF0, ST_XF1, ST_XF2, ST_VEXT,
        ST_F0, ST_F1, ST_F2, ST_F3, ST_YEXT, ST_M0, ST_M1, ST_M2, ST_MEXT,
        ST_G0, ST_G1, ST_G2, ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        MUL_XF_OLD, MUL_XF_NEW, MUL_B0, MUL_A1, MUL_A2, MUL_DRY, MUL_WET,
        MUL_GAIN_HI, MUL_GAIN_LO
    } mul_sel_t;

    typedef enum logic [1:0] {
        RD_NONE, RD_OLD, RD_NEW
    } rd_sel_t;

    typedef struct packed {
        logic     accept;
        rd_sel_t  rd_sel;
        logic     cap_old;
        logic     cap_new;
        logic     fade_upd;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_clr;
        logic     acc_sub;
        logic     acc_hi;
        logic     v_load;
        logic     y_load;
        logic     mix_load;
        logic     out_load;
    } cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/adcl_ram.sv
`default_nettype none
module adcl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/adcl_ctrl.sv
`default_nettype none
module adcl_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output adcl_pkg::cmd_t     cmd
);
    import adcl_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_RD_OLD;
            ST_RD_OLD: state_next = ST_RD_NEW;
            ST_RD_NEW: state_next = ST_XF0;
            ST_XF0:    state_next = ST_XF1;
            ST_XF1:    state_next = ST_XF2;
            ST_XF2:    state_next = ST_VEXT;
            ST_VEXT:   state_next = ST_F0;
            ST_F0:     state_next = ST_F1;
            ST_F1:     state_next = ST_F2;
            ST_F2:     state_next = ST_F3;
            ST_F3:     state_next = ST_YEXT;
            ST_YEXT:   state_next = ST_M0;
            ST_M0:     state_next = ST_M1;
            ST_M1:     state_next = ST_M2;
            ST_M2:     state_next = ST_MEXT;
            ST_MEXT:   state_next = ST_G0;
            ST_G0:     state_next = ST_G1;
            ST_G1:     state_next = ST_G2;
            ST_G2:     state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:   cmd.accept = s_tvalid;
            ST_RD_OLD: cmd.rd_sel = RD_OLD;
            ST_RD_NEW: begin
                cmd.rd_sel   = RD_NEW;
                cmd.cap_old  = 1'b1;
                cmd.fade_upd = 1'b1;
            end
            ST_XF0: begin
                cmd.cap_new = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_XF_OLD;
                cmd.acc_clr = 1'b1;
            end
            ST_XF1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_XF_NEW;
            end
            ST_VEXT: cmd.v_load = 1'b1;
            ST_F0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_B0;
                cmd.acc_clr = 1'b1;
            end
            ST_F1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_A1;
                cmd.acc_sub = 1'b1;
            end
            ST_F2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_A2;
                cmd.acc_sub = 1'b1;
            end
            ST_YEXT: cmd.y_load = 1'b1;
            ST_M0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DRY;
                cmd.acc_clr = 1'b1;
            end
            ST_M1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_WET;
            end
            ST_MEXT: cmd.mix_load = 1'b1;
            ST_G0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAIN_HI;
                cmd.acc_clr = 1'b1;
                cmd.acc_hi  = 1'b1;
            end
            ST_G1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAIN_LO;
            end
            ST_OUT: cmd.out_load = out_free;
            default: cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

>>> hw/rtl/adcl_dp.sv
`default_nettype none
module adcl_dp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire adcl_pkg::cmd_t                  cmd,
    input  wire adcl_pkg::cfg_t                  cfg,
    input  wire logic [adcl_pkg::SAMPLE_W-1:0]   sample_in,
    output logic      [adcl_pkg::SAMPLE_W-1:0]   sample_out
);
    import adcl_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(8388607);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] RND_V  = ACC_W'(1) << 15;
    localparam logic signed [ACC_W-1:0] RND_Y  = ACC_W'(1) << 21;
    localparam logic signed [ACC_W-1:0] RND_O  = ACC_W'(1) << 26;

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [ACC_W-1:0] x);
        logic signed [SAMPLE_W-1:0] r;
        if (x > SAT_HI) begin
            r = SAMPLE_W'(SAT_HI);
        end else if (x < SAT_LO) begin
            r = SAMPLE_W'(SAT_LO);
        end else begin
            r = x[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    logic signed [SAMPLE_W-1:0] x_reg, old_reg, new_reg, v_reg;
    logic signed [SAMPLE_W-1:0] x1_reg, x2_reg, y1_reg, y2_reg;
    logic        [SAMPLE_W-1:0] out_reg;
    logic        [DELAY_AW-1:0] wp_reg;
    logic                       wrapped_reg;
    logic        [TAP_W-1:0]    active_reg;
    logic        [STEP_W-1:0]   fw_reg, w_reg;
    logic signed [MIX_W-1:0]    mix_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic                       acc_en_reg, acc_clr_reg, acc_sub_reg, acc_hi_reg;
    logic                       rd_valid_reg;

    logic        [TAP_W-1:0]    tap;
    logic        [DELAY_AW-1:0] raddr;
    logic        [SAMPLE_W-1:0] rdata;
    logic signed [SAMPLE_W-1:0] rd_word;
    logic        [STEP_W-1:0]   step;
    logic        [STEP_W:0]     fw_sum;
    logic        [STEP_W-1:0]   fw_new;
    logic        [FRAC_W-1:0]   wf, dry_w;
    logic signed [MUL_B_W-1:0]  wet;
    logic signed [MUL_A_W-1:0]  s_sum, mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]    term, v_rnd, y_rnd, o_rnd;

    assign tap     = (cmd.rd_sel == RD_OLD) ? active_reg : cfg.delay_samples;
    assign raddr   = wp_reg - tap[DELAY_AW-1:0];
    assign rd_word = rd_valid_reg ? rdata : '0;

    adcl_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(DELAY_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.accept),
        .waddr (wp_reg),
        .wdata (sample_in),
        .re    (cmd.rd_sel != RD_NONE),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign step   = (cfg.xfade_step == '0) ? STEP_W'(1) : cfg.xfade_step;
    assign fw_sum = {1'b0, fw_reg} + {1'b0, step};
    assign fw_new = (fw_sum > {1'b0, WEIGHT_ONE}) ? WEIGHT_ONE : fw_sum[STEP_W-1:0];

    assign wf    = (cfg.wet_fraction > WET_ONE) ? WET_ONE : cfg.wet_fraction;
    assign dry_w = WET_ONE - wf;
    assign wet   = cfg.invert_wet ? -MUL_B_W'(y1_reg) : MUL_B_W'(y1_reg);
    assign s_sum = MUL_A_W'(v_reg) + (MUL_A_W'(x1_reg) <<< 1) + MUL_A_W'(x2_reg);

    always_comb begin
        case (cmd.mul_sel)
            MUL_XF_OLD: begin
                mul_a = MUL_A_W'(old_reg);
                mul_b = MUL_B_W'({1'b0, WEIGHT_ONE - w_reg});
            end
            MUL_XF_NEW: begin
                mul_a = MUL_A_W'(new_reg);
                mul_b = MUL_B_W'({1'b0, w_reg});
            end
            MUL_B0: begin
                mul_a = s_sum;
                mul_b = cfg.coef_b0;
            end
            MUL_A1: begin
                mul_a = MUL_A_W'(y1_reg);
                mul_b = cfg.coef_a1;
            end
            MUL_A2: begin
                mul_a = MUL_A_W'(y2_reg);
                mul_b = cfg.coef_a2;
            end
            MUL_DRY: begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = MUL_B_W'({1'b0, dry_w});
            end
            MUL_WET: begin
                mul_a = MUL_A_W'(wet);
                mul_b = MUL_B_W'({1'b0, wf});
            end
            MUL_GAIN_HI: begin
                mul_a = MUL_A_W'($signed(mix_reg[MIX_W-1:MIX_LO_W]));
                mul_b = MUL_B_W'({1'b0, cfg.gain_linear});
            end
            MUL_GAIN_LO: begin
                mul_a = MUL_A_W'({1'b0, mix_reg[MIX_LO_W-1:0]});
                mul_b = MUL_B_W'({1'b0, cfg.gain_linear});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        term = ACC_W'(prod_reg);
        if (acc_hi_reg) begin
            term = term <<< MIX_LO_W;
        end
        if (acc_sub_reg) begin
            term = -term;
        end
        acc_next = (acc_clr_reg ? '0 : acc_reg) + term;
    end

    assign v_rnd = (acc_reg + RND_V) >>> 16;
    assign y_rnd = (acc_reg + RND_Y) >>> 22;
    assign o_rnd = (acc_reg + RND_O) >>> 27;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            wrapped_reg  <= 1'b0;
            active_reg   <= '0;
            fw_reg       <= '0;
            x1_reg       <= '0;
            x2_reg       <= '0;
            y1_reg       <= '0;
            y2_reg       <= '0;
            acc_en_reg   <= 1'b0;
        end else begin
            acc_en_reg <= cmd.mul_en;
            if (cmd.fade_upd) begin
                wp_reg <= wp_reg + DELAY_AW'(1);
                if (wp_reg == '1) begin
                    wrapped_reg <= 1'b1;
                end
                if (cfg.delay_samples != active_reg) begin
                    if (fw_new == WEIGHT_ONE) begin
                        active_reg <= cfg.delay_samples;
                        fw_reg     <= '0;
                    end else begin
                        fw_reg <= fw_new;
                    end
                end else begin
                    fw_reg <= '0;
                end
            end
            if (cmd.y_load) begin
                x1_reg <= v_reg;
                x2_reg <= x1_reg;
                y1_reg <= sat24(y_rnd);
                y2_reg <= y1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_valid_reg <= wrapped_reg || (raddr <= wp_reg);
        acc_clr_reg  <= cmd.acc_clr;
        acc_sub_reg  <= cmd.acc_sub;
        acc_hi_reg   <= cmd.acc_hi;
        if (cmd.accept) begin
            x_reg <= sample_in;
        end
        if (cmd.cap_old) begin
            old_reg <= rd_word;
        end
        if (cmd.cap_new) begin
            new_reg <= rd_word;
        end
        if (cmd.fade_upd) begin
            w_reg <= (cfg.delay_samples != active_reg) ? fw_new : '0;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (acc_en_reg) begin
            acc_reg <= acc_next;
        end
        if (cmd.v_load) begin
            v_reg <= v_rnd[SAMPLE_W-1:0];
        end
        if (cmd.mix_load) begin
            mix_reg <= acc_reg[MIX_W-1:0];
        end
        if (cmd.out_load) begin
            out_reg <= sat24(o_rnd);
        end
    end

    assign sample_out = out_reg;
endmodule
`default_nettype wire

>>> hw/rtl/audio_delay_crossfade_lowpass.sv
`default_nettype none
// Audio delay with tap crossfade, biquad lowpass, wet/dry mix and output gain.
// Each input word is one signed 24-bit sample and yields one output word. A
// sample is worked through in full before a new one can be accepted, since the
// single shared 27x25 multiplier forms all nine products of the crossfade,
// filter, mix and gain one after another; the next sample is accepted once
// the result is in the output register, so a result held by the receiver
// stalls the input.
// The delay memory needs no clearing pass after reset: a wrap flag on the
// write pointer makes never-written entries read as zero.
// Write configuration only while idle.
module audio_delay_crossfade_lowpass (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [adcl_pkg::TDATA_W-1:0]      s_tdata,   // [23:0] sample_in
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [adcl_pkg::TDATA_W-1:0]      m_tdata,   // [23:0] sample_out
    input  wire logic                              cfg_wr_en,
    input  wire logic [adcl_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [adcl_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import adcl_pkg::*;

    cfg_t cfg_reg;
    cmd_t cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delay_samples <= '0;
            cfg_reg.xfade_step    <= STEP_W'(1024);
            cfg_reg.invert_wet    <= 1'b0;
            cfg_reg.wet_fraction  <= FRAC_W'(16384);
            cfg_reg.gain_linear   <= GAIN_W'(4096);
            cfg_reg.coef_b0       <= COEF_W'(1228473);
            cfg_reg.coef_a1       <= '0;
            cfg_reg.coef_a2       <= COEF_W'(719624);
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_DELAY:  cfg_reg.delay_samples <= cfg_wr_data[TAP_W-1:0];
                CFG_XFADE:  cfg_reg.xfade_step    <= cfg_wr_data[STEP_W-1:0];
                CFG_INVERT: cfg_reg.invert_wet    <= cfg_wr_data[0];
                CFG_WET:    cfg_reg.wet_fraction  <= cfg_wr_data[FRAC_W-1:0];
                CFG_GAIN:   cfg_reg.gain_linear   <= cfg_wr_data[GAIN_W-1:0];
                CFG_B0:     cfg_reg.coef_b0       <= cfg_wr_data[COEF_W-1:0];
                CFG_A1:     cfg_reg.coef_a1       <= cfg_wr_data[COEF_W-1:0];
                CFG_A2:     cfg_reg.coef_a2       <= cfg_wr_data[COEF_W-1:0];
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    adcl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    adcl_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .cfg        (cfg_reg),
        .sample_in  (s_tdata[SAMPLE_W-1:0]),
        .sample_out (m_tdata[SAMPLE_W-1:0])
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while busy");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.out_load))
        else $error("result shown without a load");
`endif
endmodule
`default_nettype wire
